>>> hdl/ibwf_pkg.sv
// Shared types and constants for the ink-bleed window filter.
package ibwf_pkg;
  localparam int MAX_RADIUS_D = 4;
  localparam int MAX_WIDTH_D  = 1024;
  localparam int MAX_HEIGHT_D = 4096;
  localparam int INK_THRESHOLD = 128;
  localparam int ALPHA_CAP     = 40;
  localparam int ALPHA_FULL    = 255;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  // Bleed alpha for radius r: min(40, 255 / (2r)).
  function automatic logic [7:0] bleed_alpha(input logic [3:0] r);
    logic [7:0] al;
    case (r)
      4'd1: al = 8'd127;
      4'd2: al = 8'd63;
      4'd3: al = 8'd42;
      4'd4: al = 8'd31;
      4'd5: al = 8'd25;
      4'd6: al = 8'd21;
      4'd7: al = 8'd18;
      4'd8: al = 8'd15;
      default: al = 8'd0;
    endcase
    return (al < 8'(ALPHA_CAP)) ? al : 8'(ALPHA_CAP);
  endfunction

  // Control between sequencer and divider.
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

>>> hdl/ibwf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ibwf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hdl/ibwf_div.sv
// Restoring divider shared by the three color channels, one quotient bit a cycle.
module ibwf_div
  import ibwf_pkg::*;
#(
  parameter int NW = 16,
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quot
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  always_comb begin
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    diff  = {1'b0, trial} - {2'b0, den};
  end

  // Shift, try subtract, keep on success
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q_r    <= num;
        rem_r  <= '0;
        cnt_r  <= CW'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[DW+1]) begin
          rem_r <= diff[DW:0];
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quot = q_r[QW-1:0];
endmodule

>>> hdl/ink_bleed_window_filter_unit.sv
// Top level of the ink-bleed window filter: line ring, window walk sequencer, output stage.
//
//  channel | ports                                   | handshake
//  in      | in_pixel_valid .. in_blue               | in_valid / in_ready
//  out     | out_alpha .. out_last_of_frame          | out_valid / out_ready
//  cfg     | cfg_we, cfg_index, cfg_data             | write on cfg_we, no wait
//
// Each input item takes a store step (S_IDLE), a check step (S_CHECK), and if a
// result is due a read of the center (S_RD_C, S_WAIT_C, S_CENTER) and an output
// step (S_OUT); a bleed candidate walks (2R+1)^2 neighbors at one line-memory read
// a cycle, drains the read pipe, then runs three divisions, one per color channel.
// The single memory read port and the shared divider set the time.
// Reset (rst_n low, synchronous) clears positions, state and config registers to defaults;
// the line store is not cleared. in_ready is high only while the sequencer is
// idle; a result that is still waiting holds the sequencer in its output step.
module ink_bleed_window_filter_unit
  import ibwf_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_D,
  parameter int MAX_WIDTH  = MAX_WIDTH_D,
  parameter int MAX_HEIGHT = MAX_HEIGHT_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_pixel_valid,
  input  logic        in_frame_start,
  input  logic [7:0]  in_alpha,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_alpha,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_bled,
  output logic        out_last_of_frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int RING   = 2 * MAX_RADIUS + 1;
  localparam int CWW    = $clog2(MAX_WIDTH);
  localparam int RWW    = $clog2(RING);
  localparam int DEPTH  = RING * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int PW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int RDW    = $clog2(MAX_RADIUS + 1);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int CNTW   = $clog2(RING * RING + 1);
  localparam int SUMW   = CNTW + 8;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD_C, S_WAIT_C, S_CENTER, S_WALK, S_WALK_END,
    S_DIV_R, S_DIV_G, S_DIV_B, S_OUT
  } state_t;

  // Config registers
  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  radius_r;
  logic [WW-1:0]  w_eff;
  logic [HW-1:0]  h_eff;
  logic [RDW-1:0] r_eff;
  logic [PW-1:0]  total_r;
  logic [PW-1:0]  lag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd1024;
      height_r <= 13'd1024;
      radius_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[10:0];
        REG_HEIGHT: height_r <= cfg_data;
        REG_RADIUS: radius_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) w_eff = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);
    if (height_r == '0) h_eff = HW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_r);
    if (32'(radius_r) > MAX_RADIUS) r_eff = RDW'(MAX_RADIUS);
    else r_eff = RDW'(radius_r);
  end

  // Products registered from config (the user must hold config static while idle; the block does not enforce it)
  always_ff @(posedge clk) begin
    total_r <= PW'(w_eff * h_eff);
    lag_r   <= PW'(r_eff * w_eff + r_eff);
  end

  // Position state: linear count plus column/row counters
  logic [PW-1:0]  in_pos_r, out_pos_r;
  logic [CWW-1:0] in_col_r, out_col_r;
  logic [RWW-1:0] in_ring_r, out_ring_r;
  logic [YW-1:0]  out_row_r;

  state_t state_r;
  logic [7:0]  a_r, red_r, grn_r, blu_r;
  logic        bled_r, last_r;
  logic        out_valid_r;
  logic [7:0]  res_alpha_r, res_red_r, res_green_r, res_blue_r;
  logic        res_bled_r, res_last_r;

  // Window walk
  logic [RWW-1:0] wy_ring_r;
  logic [3:0]     wy_r, wx_r;
  logic [CWW-1:0] wcol_r;
  logic           rd_pend_r, rd_pend2_r;
  logic [SUMW-1:0] sr_r, sg_r, sb_r;
  logic [CNTW-1:0] cnt_r;

  // Memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  logic [RWW-1:0] rd_ring;
  logic [CWW-1:0] rd_col;

  assign we    = (state_r == S_IDLE) && in_valid && in_ready && in_pixel_valid &&
                 ((in_frame_start ? PW'(0) : in_pos_r) < total_r);
  assign waddr = AW'(in_frame_start ? '0 : (32'(in_ring_r) * MAX_WIDTH + 32'(in_col_r)));
  assign raddr = AW'(32'(rd_ring) * MAX_WIDTH + 32'(rd_col));

  ibwf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr,
    .wdata({in_alpha, in_red, in_green, in_blue}),
    .raddr, .rdata
  );

  // Divider
  div_ctl_t div_ctl;
  logic          div_done;
  logic [7:0]    div_q;
  logic [SUMW-1:0] div_num;

  ibwf_div #(.NW(SUMW), .DW(CNTW), .QW(8)) u_div (
    .clk, .rst_n, .start(div_ctl.start), .num(div_num), .den(cnt_r),
    .done(div_done), .quot(div_q)
  );

  assign in_ready = (state_r == S_IDLE);

  logic ready_now;
  logic [PW-1:0] out_minus;
  assign out_minus = in_pos_r - out_pos_r;
  assign ready_now = (out_pos_r < total_r) && (out_pos_r < in_pos_r) &&
                     ((in_pos_r >= total_r) || (out_minus > lag_r));

  logic [RWW-1:0] ring_start;
  logic cand;
  logic center_rd;
  always_comb begin
    ring_start = (out_ring_r >= RWW'(r_eff)) ? out_ring_r - RWW'(r_eff)
                                              : RWW'(32'(out_ring_r) + RING - 32'(r_eff));
    cand = (r_eff != '0) && (32'(out_col_r) >= 32'(r_eff)) &&
           (32'(out_col_r) + 32'(r_eff) < 32'(w_eff)) &&
           (32'(out_row_r) >= 32'(r_eff)) &&
           (32'(out_row_r) + 32'(r_eff) < 32'(h_eff));
    // Keep the center address up until the center word is taken
    center_rd = (state_r == S_RD_C) || (state_r == S_WAIT_C);
    rd_ring = center_rd ? out_ring_r : wy_ring_r;
    rd_col  = center_rd ? out_col_r  : wcol_r;
    div_ctl.busy = (state_r == S_DIV_R) || (state_r == S_DIV_G) || (state_r == S_DIV_B);
    div_ctl.start = 1'b0;
    div_num = sr_r;
    if (state_r == S_WALK_END && !rd_pend_r && !rd_pend2_r) div_ctl.start = (cnt_r != '0);
    if (state_r == S_DIV_R && div_done) begin div_ctl.start = 1'b1; div_num = sg_r; end
    if (state_r == S_DIV_G && div_done) begin div_ctl.start = 1'b1; div_num = sb_r; end
  end

  logic [3:0] wspan;
  assign wspan = 4'(2 * 32'(r_eff));
  logic inked;
  assign inked = rdata[31:24] > 8'(INK_THRESHOLD);

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      in_col_r    <= '0;
      in_ring_r   <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_ring_r  <= '0;
      rd_pend_r   <= 1'b0;
      rd_pend2_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_pixel_valid && in_frame_start) begin
              out_pos_r  <= '0;
              out_col_r  <= '0;
              out_row_r  <= '0;
              out_ring_r <= '0;
            end
            if (we) begin
              in_pos_r <= (in_frame_start ? PW'(0) : in_pos_r) + 1'b1;
              if (in_frame_start) begin
                in_col_r  <= (w_eff == WW'(1)) ? '0 : CWW'(1);
                in_ring_r <= (w_eff == WW'(1)) ? RWW'(1) : '0;
              end else if (32'(in_col_r) + 1 >= 32'(w_eff)) begin
                in_col_r  <= '0;
                in_ring_r <= (32'(in_ring_r) == RING - 1) ? '0 : in_ring_r + 1'b1;
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end else if (in_pixel_valid && in_frame_start) begin
              in_pos_r <= '0;
            end
            state_r <= S_CHECK;
          end
        end
        S_CHECK: state_r <= ready_now ? S_RD_C : S_IDLE;
        S_RD_C: state_r <= S_WAIT_C;
        S_WAIT_C: state_r <= S_CENTER;
        S_CENTER: begin
          a_r    <= rdata[31:24];
          red_r  <= rdata[23:16];
          grn_r  <= rdata[15:8];
          blu_r  <= rdata[7:0];
          bled_r <= 1'b0;
          last_r <= (out_pos_r + 1'b1 == total_r);
          sr_r <= '0; sg_r <= '0; sb_r <= '0; cnt_r <= '0;
          wy_r <= '0; wx_r <= '0;
          wy_ring_r <= ring_start;
          wcol_r <= out_col_r - CWW'(r_eff);
          rd_pend_r <= 1'b0; rd_pend2_r <= 1'b0;
          state_r <= (cand && rdata[31:24] == 8'd0) ? S_WALK : S_OUT;
        end
        S_WALK, S_WALK_END: begin
          // Issue one neighbor read a cycle, accumulate its word in the cycle after
          rd_pend_r  <= (state_r == S_WALK);
          rd_pend2_r <= rd_pend_r;
          if (rd_pend_r && inked) begin
            sr_r  <= sr_r + SUMW'(rdata[23:16]);
            sg_r  <= sg_r + SUMW'(rdata[15:8]);
            sb_r  <= sb_r + SUMW'(rdata[7:0]);
            cnt_r <= cnt_r + 1'b1;
          end
          if (state_r == S_WALK) begin
            if (wx_r == wspan) begin
              wx_r   <= '0;
              wcol_r <= out_col_r - CWW'(r_eff);
              wy_r   <= wy_r + 1'b1;
              wy_ring_r <= (32'(wy_ring_r) == RING - 1) ? '0 : wy_ring_r + 1'b1;
              if (wy_r == wspan) state_r <= S_WALK_END;
            end else begin
              wx_r   <= wx_r + 1'b1;
              wcol_r <= wcol_r + 1'b1;
            end
          end else if (!rd_pend_r && !rd_pend2_r) begin
            state_r <= (cnt_r != '0) ? S_DIV_R : S_OUT;
          end
        end
        S_DIV_R: if (div_done) begin red_r <= div_q; state_r <= S_DIV_G; end
        S_DIV_G: if (div_done) begin grn_r <= div_q; state_r <= S_DIV_B; end
        S_DIV_B: if (div_done) begin
          blu_r  <= div_q;
          a_r    <= bleed_alpha(4'(r_eff));
          bled_r <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold until the result register is free, then load it and advance
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            res_alpha_r <= a_r;
            res_red_r   <= red_r;
            res_green_r <= grn_r;
            res_blue_r  <= blu_r;
            res_bled_r  <= bled_r;
            res_last_r  <= last_r;
            out_pos_r   <= out_pos_r + 1'b1;
            if (32'(out_col_r) + 1 >= 32'(w_eff)) begin
              out_col_r  <= '0;
              out_row_r  <= out_row_r + 1'b1;
              out_ring_r <= (32'(out_ring_r) == RING - 1) ? '0 : out_ring_r + 1'b1;
            end else begin
              out_col_r <= out_col_r + 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alpha         = res_alpha_r;
  assign out_red           = res_red_r;
  assign out_green         = res_green_r;
  assign out_blue          = res_blue_r;
  assign out_bled          = res_bled_r;
  assign out_last_of_frame = res_last_r;

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_out_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pos_r <= in_pos_r)) else $error("output position overrun");
  a_div_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> div_ctl.busy) else $error("divider done outside divide states");
  a_bled_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bled) |-> (out_alpha <= 8'(ALPHA_CAP))) else $error("bad bleed alpha");
endmodule

>>> tb/ibwf_checker.sv
// Checker for the ink-bleed window filter: snoops all ports, predicts and compares results.
module ibwf_checker
  import ibwf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_pixel_valid,
  input  logic        in_frame_start,
  input  logic [7:0]  in_alpha,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_alpha,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        out_bled,
  input  logic        out_last_of_frame,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          mismatch_count,
  output int          pixels_owed
);
  localparam int RING_ROWS = 2 * MAX_RADIUS_D + 1;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       bled;
    logic       last;
  } pixel_out_t;

  logic [31:0] ring_mem [RING_ROWS * MAX_WIDTH_D];
  int unsigned in_pos, out_pos;
  logic [10:0] width_reg;
  logic [12:0] height_reg;
  logic [2:0]  radius_reg;
  pixel_out_t  owed_q[$];

  assign pixels_owed = owed_q.size();

  function automatic int unsigned ring_slot(int unsigned row, int unsigned col);
    return (row % RING_ROWS) * MAX_WIDTH_D + (col % MAX_WIDTH_D);
  endfunction

  // Advance the filter model by one accepted transfer; queue any result it yields.
  task automatic filter_step(logic pv, logic fs, logic [31:0] argb);
    int unsigned w, h, r, total, lag, col, row, y, x, cnt, sr, sg, sb, al;
    logic [31:0] px, np;
    pixel_out_t res;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH_D) ? MAX_WIDTH_D : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT_D) ? MAX_HEIGHT_D : height_reg);
    r = (radius_reg > MAX_RADIUS_D) ? MAX_RADIUS_D : radius_reg;
    total = w * h;
    lag = r * w + r;
    if (pv) begin
      if (fs) begin
        in_pos = 0;
        out_pos = 0;
      end
      if (in_pos < total) begin
        ring_mem[ring_slot(in_pos / w, in_pos % w)] = argb;
        in_pos++;
      end
    end
    if (out_pos >= total || out_pos >= in_pos) return;
    if (!(in_pos >= total || in_pos - out_pos > lag)) return;
    col = out_pos % w;
    row = out_pos / w;
    px = ring_mem[ring_slot(row, col)];
    res = '{px[31:24], px[23:16], px[15:8], px[7:0], 1'b0, 1'b0};
    if (r > 0 && px[31:24] == 0 && col >= r && col + r < w && row >= r && row + r < h) begin
      cnt = 0; sr = 0; sg = 0; sb = 0;
      for (y = row - r; y <= row + r; y++)
        for (x = col - r; x <= col + r; x++) begin
          np = ring_mem[ring_slot(y, x)];
          if (np[31:24] > INK_THRESHOLD) begin
            sr += np[23:16];
            sg += np[15:8];
            sb += np[7:0];
            cnt++;
          end
        end
      if (cnt > 0) begin
        al = ALPHA_FULL / (2 * r);
        res.alpha = (al < ALPHA_CAP) ? 8'(al) : 8'(ALPHA_CAP);
        res.red = 8'(sr / cnt);
        res.green = 8'(sg / cnt);
        res.blue = 8'(sb / cnt);
        res.bled = 1'b1;
      end
    end
    res.last = (out_pos + 1 == total);
    out_pos++;
    owed_q.insert(owed_q.size(), res);
  endtask

  always @(posedge clk) begin
    pixel_out_t got, want;
    if (!rst_n) begin
      in_pos = 0;
      out_pos = 0;
      width_reg = 11'd1024;
      height_reg = 13'd1024;
      radius_reg = 3'd1;
      owed_q.delete();
      mismatch_count <= 0;
    end else begin
      // Compare an output transfer against the oldest owed pixel
      if (out_valid && out_ready) begin
        got = '{out_alpha, out_red, out_green, out_blue, out_bled, out_last_of_frame};
        if (owed_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected output transfer: a=%0d r=%0d g=%0d b=%0d bled=%0b last=%0b",
                     got.alpha, got.red, got.green, got.blue, got.bled, got.last);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("pixel mismatch: exp a=%0d r=%0d g=%0d b=%0d bled=%0b last=%0b",
                       want.alpha, want.red, want.green, want.blue, want.bled, want.last);
              $display("                got a=%0d r=%0d g=%0d b=%0d bled=%0b last=%0b",
                       got.alpha, got.red, got.green, got.blue, got.bled, got.last);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH:  width_reg = cfg_data[10:0];
          REG_HEIGHT: height_reg = cfg_data;
          REG_RADIUS: radius_reg = cfg_data[2:0];
          default: ;
        endcase
      end
      // Predict from an input transfer
      if (in_valid && in_ready)
        filter_step(in_pixel_valid, in_frame_start, {in_alpha, in_red, in_green, in_blue});
    end
  end
endmodule

>>> tb/testbench.sv
// Testbench top for the ink-bleed window filter: clock, reset, stimulus and verdict.
module testbench;
  import ibwf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_pixel_valid = 1'b0;
  logic        in_frame_start = 1'b0;
  logic [7:0]  in_alpha = '0, in_red = '0, in_green = '0, in_blue = '0;
  logic        out_valid, out_ready = 1'b0;
  logic [7:0]  out_alpha, out_red, out_green, out_blue;
  logic        out_bled, out_last_of_frame;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [12:0] cfg_data = '0;
  int          mismatch_count, pixels_owed;
  int          sent_items = 0;
  int          stall_left = 0;
  bit          calm_phase = 1'b0;

  always #5 clk = ~clk;

  ink_bleed_window_filter_unit u_dut (.*);

  ibwf_checker u_checker (.*);

  function automatic int gap_len();
    int pick;
    if (calm_phase) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Stall the result side at random: mostly short drops, now and then a long hold
  always @(negedge clk) begin
    if (calm_phase) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(15, 60);
    end else begin
      out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  // Hand one item to the block and hold it until the transfer
  task automatic send_item(logic pv, logic fs, logic [7:0] a, r, g, b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_pixel_valid = pv;
    in_frame_start = fs;
    in_alpha = a; in_red = r; in_green = g; in_blue = b;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_pixel(logic fs);
    int pick;
    logic [7:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 40) a = 8'd0;
    else if (pick < 75) a = 8'($urandom_range(129, 255));
    else if (pick < 80) a = 8'd128;
    else a = 8'($urandom_range(0, 255));
    send_item(1'b1, fs, a, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_drain(int n);
    repeat (n) send_item(1'b0, 1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
  endtask

  // Let everything owed come out, then let the block settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pixels_owed != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_shape(int w, int h, int r);
    wait_idle();
    write_reg(REG_WIDTH, 13'(w));
    write_reg(REG_HEIGHT, 13'(h));
    write_reg(REG_RADIUS, 13'(r));
  endtask

  // Stream one image; optionally cut it short or overrun its end
  task automatic send_image(int w, int h, int r);
    int n, mode, lag;
    mode = $urandom_range(0, 9);
    n = w * h;
    if (mode == 0) n = $urandom_range(1, n);
    else if (mode == 1) n = n + $urandom_range(1, 4);
    lag = r * w + r;
    for (int i = 0; i < n; i++) begin
      send_pixel(i == 0);
      if ($urandom_range(0, 49) == 0) send_drain(1);
    end
    if (mode != 0 || $urandom_range(0, 1)) send_drain(lag + $urandom_range(1, 3));
  endtask

  initial begin
    int w, h, r;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Pixels without a frame start at reset shape, plus early drains
    calm_phase = 1'b1;
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_drain(2);
    calm_phase = 1'b0;

    // Zero width and height read as one, zero radius passes through
    set_shape(0, 0, 0);
    send_pixel(1'b1);
    send_drain(1);

    // 3x3 bleed: transparent center, inked edge neighbors, corners at the threshold (not inked)
    set_shape(3, 3, 1);
    for (int i = 0; i < 9; i++)
      send_item(1'b1, i == 0, (i == 4) ? 8'd0 : ((i % 2) ? 8'd255 : 8'd128),
                8'(i * 30), 8'hFF, 8'h00);
    send_drain(2);

    // Oversized registers clamp to their maximums
    set_shape(2047, 8191, 7);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_drain(2);

    // Radius-4 image at minimum bleed size
    set_shape(9, 9, 4);
    send_image(9, 9, 4);

    // Random images until the item budget is spent
    while (sent_items < 1800) begin
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      r = $urandom_range(0, 7);
      set_shape(w, h, r);
      calm_phase = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 3)) send_image(w, h, (r > 4) ? 4 : r);
      calm_phase = 1'b0;
    end

    wait_idle();
    if (mismatch_count == 0 && pixels_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
